// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the partition choice block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PCSP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("%m: check failed");
`define PCSP_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define PCSP_ASSERT(lbl, clk, rst_n, prop)
`define PCSP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/pcsp_pkg.sv =====
package pcsp_pkg;

	localparam int TIME_BITS       = 16;
	localparam int EXP_TABLE_DEPTH = 256; // power of two
	localparam int EXP_IDX_BITS    = $clog2(EXP_TABLE_DEPTH);
	localparam int DIV_STEPS       = 17;
	localparam int DIV_W           = 32;
	localparam int ADDR_W          = 4;

	localparam logic [15:0] TIME_MASK = (TIME_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << TIME_BITS) - 32'd1);
	localparam logic [31:0] Q30_ONE   = 32'h4000_0000;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [16:0] PROB_ONE  = 17'd65536;
	localparam logic [16:0] PROB_HALF = 17'd32768;
	localparam logic [16:0] PROB_ZERO = 17'd0;
	localparam logic [15:0] RATIO_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		INFO_BOTH   = 2'd0,
		INFO_NONE   = 2'd1,
		INFO_ONLY_B = 2'd2,
		INFO_ONLY_A = 2'd3
	} info_t;

	typedef enum logic [1:0] {
		REG_METHOD     = 2'd0,
		REG_REACTIVITY = 2'd1,
		REG_OFFSET     = 2'd2,
		REG_GAIN       = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic        method;
		logic [15:0] reactivity;
		logic [15:0] offset;
		logic [16:0] gain;
	} cfg_t;

	typedef struct packed {
		logic [DIV_W-1:0]     rem;
		logic [DIV_STEPS-1:0] low;
		logic [DIV_W-1:0]     den;
	} div_req_t;

	typedef struct packed {
		info_t info;
		logic  zero;
		logic  sat;
	} side_t;

	typedef struct packed {
		div_req_t req;
		logic     zero;
		logic     sat;
	} ratio_setup_t;

	typedef logic [30:0] exp_tab_t [EXP_TABLE_DEPTH];

	// 2^30 * exp(-i*ln2/depth), 13-term Taylor series in Q30
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t           tab;
		logic [63:0]        a;
		logic [63:0]        term;
		logic signed [63:0] sum;
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			a    = (64'(i) * 64'd744261118) / 64'(EXP_TABLE_DEPTH);
			term = 64'd1 << 30;
			sum  = $signed(64'd1 << 30);
			for (int k = 1; k <= 12; k++) begin
				term = ((term * a) >> 30) / 64'(k);
				if ((k & 1) == 1)
					sum = sum - $signed(term);
				else
					sum = sum + $signed(term);
			end
			tab[i] = 31'(sum);
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

	// |root-(left+right)| << 12 over root, set up for the divider
	function automatic ratio_setup_t ratio_setup(logic [15:0] root_i, logic [15:0] left_i,
		logic [15:0] right_i);
		ratio_setup_t rs;
		logic [16:0]  r;
		logic [16:0]  s;
		logic [16:0]  num;
		r   = {1'b0, root_i & TIME_MASK};
		s   = {1'b0, left_i & TIME_MASK} + {1'b0, right_i & TIME_MASK};
		num = (r > s) ? (r - s) : (s - r);
		rs.zero    = (r == 17'd0);
		rs.sat     = ({3'b000, num} >= {r[15:0], 4'b0000});
		rs.req.rem = DIV_W'(num[16:5]);
		rs.req.low = {num[4:0], 12'b0};
		rs.req.den = DIV_W'(r[15:0]);
		return rs;
	endfunction

endpackage

// ===== hw/rtl/pcsp_cfg_regs.sv =====
module pcsp_cfg_regs import pcsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.method     <= 1'b0;
			cfg_q.reactivity <= 16'd2048;
			cfg_q.offset     <= 16'd256;
			cfg_q.gain       <= 17'd65536;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_METHOD:     cfg_q.method     <= pwdata[0];
				REG_REACTIVITY: cfg_q.reactivity <= pwdata[15:0];
				REG_OFFSET:     cfg_q.offset     <= pwdata[15:0];
				REG_GAIN:       cfg_q.gain       <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_METHOD:     prdata = 32'(cfg_q.method);
			REG_REACTIVITY: prdata = 32'(cfg_q.reactivity);
			REG_OFFSET:     prdata = 32'(cfg_q.offset);
			REG_GAIN:       prdata = 32'(cfg_q.gain);
			default:        prdata = 32'd0;
		endcase
	end

endmodule

// ===== hw/rtl/pcsp_div_pipe.sv =====
`include "assert_macros.svh"
// Restoring divider, one quotient bit per stage. Needs rem < den on entry.
module pcsp_div_pipe import pcsp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  div_req_t             in_req,
	input  side_t                in_side,
	output logic                 out_vld,
	output logic [DIV_STEPS-1:0] out_quo,
	output side_t                out_side
);

	logic [DIV_STEPS-1:0] vld_s;
	logic [DIV_W-1:0]     rem_s  [DIV_STEPS];
	logic [DIV_STEPS-1:0] low_s  [DIV_STEPS];
	logic [DIV_W-1:0]     den_s  [DIV_STEPS];
	side_t                side_s [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic                 vld_in;
		logic [DIV_W-1:0]     rem_in;
		logic [DIV_STEPS-1:0] low_in;
		logic [DIV_W-1:0]     den_in;
		side_t                side_in;
		logic [DIV_W:0]       trial;
		logic                 take;

		if (k == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rem_in  = in_req.rem;
			assign low_in  = in_req.low;
			assign den_in  = in_req.den;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign low_in  = low_s[k-1];
			assign den_in  = den_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign trial = {rem_in, low_in[DIV_STEPS-1]};
		assign take  = (trial >= {1'b0, den_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? DIV_W'(trial - {1'b0, den_in}) : trial[DIV_W-1:0];
				low_s[k]  <= {low_in[DIV_STEPS-2:0], take};
				den_s[k]  <= den_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[DIV_STEPS-1];
	assign out_quo  = low_s[DIV_STEPS-1];
	assign out_side = side_s[DIV_STEPS-1];

	`PCSP_ASSERT(a_div_hold, clk, arst_n, !en |=> $stable(vld_s))

endmodule

// ===== hw/rtl/pcsp_exp_unit.sv =====
`include "assert_macros.svh"
// Sigmoid front end: theta, exp by table and shift, then numerator and
// denominator for the final divide.
module pcsp_exp_unit import pcsp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  cfg_t                 cfg,
	input  logic                 in_vld,
	input  logic [DIV_STEPS-1:0] in_quo,
	input  side_t                in_side,
	output logic                 out_vld,
	output div_req_t             out_req,
	output side_t                out_side
);

	logic [4:0] vld_s;

	logic signed [33:0] theta_s1;
	info_t              info_s1, info_s2, info_s3, info_s4, info_s5;
	logic [31:0]        x_s2;
	logic               neg_s2, neg_s3, neg_s4;
	logic [32:0]        y_s3;
	logic [30:0]        e_s4;
	div_req_t           req_s5;

	logic [15:0]        q;
	logic signed [16:0] diff;
	logic [48:0]        prod;
	logic [16:0]        n_int;
	logic [30:0]        tab_val;
	logic [31:0]        m;
	logic [47:0]        num;

	assign q    = in_side.sat ? RATIO_MAX : in_quo[15:0];
	assign diff = $signed({1'b0, cfg.offset}) - $signed({1'b0, q});
	assign prod = 49'(x_s2) * 49'(LOG2E_Q16);
	assign n_int   = y_s3[32:16];
	assign tab_val = EXP_TAB[y_s3[15 -: EXP_IDX_BITS]];
	assign m   = neg_s4 ? {1'b0, e_s4} : Q30_ONE;
	assign num = 48'(cfg.gain) * 48'(m[30:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[3:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			theta_s1 <= $signed({1'b0, cfg.reactivity}) * diff;
			info_s1  <= in_side.info;

			neg_s2  <= theta_s1[33];
			x_s2    <= theta_s1[33] ? 32'(-theta_s1) : 32'(theta_s1);
			info_s2 <= info_s1;

			y_s3    <= prod[48:16];
			neg_s3  <= neg_s2;
			info_s3 <= info_s2;

			e_s4    <= (n_int >= 17'd31) ? 31'd0 : (tab_val >> n_int[4:0]);
			neg_s4  <= neg_s3;
			info_s4 <= info_s3;

			req_s5.rem <= DIV_W'(num[47:17]);
			req_s5.low <= num[16:0];
			req_s5.den <= Q30_ONE + {1'b0, e_s4};
			info_s5    <= info_s4;
		end
	end

	assign out_vld       = vld_s[4];
	assign out_req       = req_s5;
	assign out_side.info = info_s5;
	assign out_side.zero = 1'b0;
	assign out_side.sat  = 1'b0;

	`PCSP_ASSERT(a_exp_range, clk, arst_n, vld_s[3] |-> ({1'b0, e_s4} <= Q30_ONE))

endmodule

// ===== hw/rtl/partition_choice_sigmoid_probability_top.sv =====
// Channel  | valid     | stall     | payload
// -------- | --------- | --------- | -----------------------------------------
// request  | in_valid  | in_stall  | root/left/right_time_a, root/left/right_time_b
// result   | out_valid | out_stall | probability, info_case
// config   | APB psel/penable/pwrite, paddr, pwdata, prdata, pready (always 1)
//
// One request enters every cycle unless the pipeline is halted; a result passes
// through the ratio stage, 17-stage ratio divider, setup, 17-stage quotient divider,
// 5-stage exp unit, 17-stage final divider and output register.
// The whole pipeline advances on one enable: it halts only while a result
// waits at the output under stall, so in_stall follows out_stall then.
// Reset clears the valid bits and loads the register defaults.
`include "assert_macros.svh"
module partition_choice_sigmoid_probability_top import pcsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [15:0]       root_time_a,
	input  logic [15:0]       left_time_a,
	input  logic [15:0]       right_time_a,
	input  logic [15:0]       root_time_b,
	input  logic [15:0]       left_time_b,
	input  logic [15:0]       right_time_b,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [16:0]       probability,
	output logic [1:0]        info_case,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t cfg;
	logic en;

	// stage 1: ratio numerators and saturation flags
	ratio_setup_t rs_a, rs_b;
	logic         vld_s1;
	div_req_t     req_a_s1, req_b_s1;
	side_t        side_a_s1, side_b_s1;

	// ratio dividers
	logic                 vld_da, vld_db;
	logic [DIV_STEPS-1:0] quo_a, quo_b;
	side_t                side_da, side_db;

	// stage 2: info code and quotient setup
	logic [15:0] ra, rb;
	info_t       info;
	logic        vld_s2;
	div_req_t    req_q_s2;
	side_t       side_q_s2;

	logic                 vld_dq;
	logic [DIV_STEPS-1:0] quo_q;
	side_t                side_dq;

	logic     vld_x;
	div_req_t req_x;
	side_t    side_x;

	logic                 vld_df;
	logic [DIV_STEPS-1:0] quo_f;
	side_t                side_df;

	// stage 3: output register
	logic        vld_s3;
	logic [16:0] prob_s3;
	info_t       info_s3;
	logic [16:0] prob_sig;
	logic [16:0] prob_next;

	assign en       = !(vld_s3 && out_stall);
	assign in_stall = !en;

	pcsp_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	assign rs_a = ratio_setup(root_time_a, left_time_a, right_time_a);
	assign rs_b = ratio_setup(root_time_b, left_time_b, right_time_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_da && vld_db;
			vld_s3 <= vld_df;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_a_s1  <= rs_a.req;
			req_b_s1  <= rs_b.req;
			side_a_s1 <= '{info: INFO_BOTH, zero: rs_a.zero, sat: rs_a.sat};
			side_b_s1 <= '{info: INFO_BOTH, zero: rs_b.zero, sat: rs_b.sat};
		end
	end

	pcsp_div_pipe u_div_a (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1), .in_req(req_a_s1),
		.in_side(side_a_s1), .out_vld(vld_da), .out_quo(quo_a), .out_side(side_da)
	);

	pcsp_div_pipe u_div_b (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1), .in_req(req_b_s1),
		.in_side(side_b_s1), .out_vld(vld_db), .out_quo(quo_b), .out_side(side_db)
	);

	// Q4.12 ratios; zero root means no information
	always_comb begin
		ra = side_da.zero ? 16'd0 : (side_da.sat ? RATIO_MAX : quo_a[15:0]);
		rb = side_db.zero ? 16'd0 : (side_db.sat ? RATIO_MAX : quo_b[15:0]);
		if (ra != 16'd0 && rb != 16'd0)
			info = INFO_BOTH;
		else if (ra == 16'd0 && rb == 16'd0)
			info = INFO_NONE;
		else if (ra == 16'd0)
			info = INFO_ONLY_B;
		else
			info = INFO_ONLY_A;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_q_s2.rem <= DIV_W'(ra[15:9]);
			req_q_s2.low <= {ra[8:0], 8'b0};
			req_q_s2.den <= DIV_W'(rb);
			side_q_s2    <= '{info: info, zero: 1'b0,
				sat: ({8'b0, ra} >= {rb, 8'b0})};
		end
	end

	pcsp_div_pipe u_div_q (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s2), .in_req(req_q_s2),
		.in_side(side_q_s2), .out_vld(vld_dq), .out_quo(quo_q), .out_side(side_dq)
	);

	pcsp_exp_unit u_exp (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg), .in_vld(vld_dq), .in_quo(quo_q),
		.in_side(side_dq), .out_vld(vld_x), .out_req(req_x), .out_side(side_x)
	);

	pcsp_div_pipe u_div_f (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_x), .in_req(req_x),
		.in_side(side_x), .out_vld(vld_df), .out_quo(quo_f), .out_side(side_df)
	);

	// gain above one can push the sigmoid past one: clamp
	assign prob_sig = (quo_f > PROB_ONE) ? PROB_ONE : quo_f;

	always_comb begin
		if (cfg.method || side_df.info == INFO_NONE)
			prob_next = PROB_HALF;
		else if (side_df.info == INFO_ONLY_B)
			prob_next = PROB_ZERO;
		else if (side_df.info == INFO_ONLY_A)
			prob_next = PROB_ONE;
		else
			prob_next = prob_sig;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prob_s3 <= prob_next;
			info_s3 <= side_df.info;
		end
	end

	assign out_valid   = vld_s3;
	assign probability = prob_s3;
	assign info_case   = info_s3;

	`PCSP_ASSERT_ALWAYS(a_stall_gate, clk, (out_valid && out_stall) |-> in_stall)
	`PCSP_ASSERT(a_none_half, clk, arst_n, (out_valid && info_case == INFO_NONE) |-> (probability == PROB_HALF))
	`PCSP_ASSERT(a_prob_max, clk, arst_n, out_valid |-> (probability <= PROB_ONE))

endmodule
